FILE: rtl/core/zrwp_pkg.sv
// zrwp_pkg: shared types, constants and angle tables for the zone-to-world point block.
// Used by zrwp_cfg_regs, zrwp_datapath and zone_range_to_world_point_top.
// No dependencies.
package zrwp_pkg;

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 64;
    localparam int REG_W   = 48;
    localparam int COEF_W  = 16;
    localparam int DIST_W  = 16;
    localparam int IDX_W   = 3;
    localparam int COORD_W = 18;
    localparam int NUM_AXES = 3;

    // Register map: register i at byte address 8*i
    typedef enum logic [1:0] {
        REG_ROT_ROW0 = 2'd0,
        REG_ROT_ROW1 = 2'd1,
        REG_ROT_ROW2 = 2'd2,
        REG_TRANS    = 2'd3
    } reg_idx_t;

    // Reset is the identity matrix (1.0 in Q2.14) and zero translation
    localparam logic [REG_W-1:0] ROT_ROW0_RST = 48'h0000_0000_4000;
    localparam logic [REG_W-1:0] ROT_ROW1_RST = 48'h0000_4000_0000;
    localparam logic [REG_W-1:0] ROT_ROW2_RST = 48'h4000_0000_0000;
    localparam logic [REG_W-1:0] TRANS_RST    = 48'h0000_0000_0000;

    // Half an output LSB at Q42, rounds to nearest with ties upward
    localparam logic signed [63:0] ROUND_HALF = 64'sh0000_0200_0000_0000;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 18'sh1FFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 18'sh20000;

    typedef struct packed {
        logic [REG_W-1:0] rot_row2;
        logic [REG_W-1:0] rot_row1;
        logic [REG_W-1:0] rot_row0;
        logic [REG_W-1:0] trans;
    } cfg_t;

    // Signed 16-bit lane of a packed 48-bit register
    function automatic logic signed [COEF_W-1:0] lane16(input logic [REG_W-1:0] w,
                                                        input logic [1:0] idx);
        lane16 = $signed(w[COEF_W*idx +: COEF_W]);
    endfunction

    // Angles span 45 degrees in 8 entries, entries are Q2.14
    function automatic logic signed [COEF_W-1:0] sin_q14(input logic [IDX_W-1:0] i);
        unique case (i)
            3'd0:    sin_q14 = -16'sd6270;
            3'd1:    sin_q14 = -16'sd4536;
            3'd2:    sin_q14 = -16'sd2744;
            3'd3:    sin_q14 = -16'sd919;
            3'd4:    sin_q14 = 16'sd919;
            3'd5:    sin_q14 = 16'sd2744;
            3'd6:    sin_q14 = 16'sd4536;
            3'd7:    sin_q14 = 16'sd6270;
            default: sin_q14 = 16'sd0;
        endcase
    endfunction

    function automatic logic signed [COEF_W-1:0] cos_q14(input logic [IDX_W-1:0] i);
        unique case (i)
            3'd0, 3'd7: cos_q14 = 16'sd15137;
            3'd1, 3'd6: cos_q14 = 16'sd15744;
            3'd2, 3'd5: cos_q14 = 16'sd16153;
            3'd3, 3'd4: cos_q14 = 16'sd16358;
            default:    cos_q14 = 16'sd0;
        endcase
    endfunction

endpackage

FILE: rtl/core/zrwp_cfg_regs.sv
// zrwp_cfg_regs: APB-style register file for rotation rows and translation.
// Depends on zrwp_pkg.
module zrwp_cfg_regs
    import zrwp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    logic [REG_W-1:0] rot_row0_reg, rot_row1_reg, rot_row2_reg, trans_reg;
    logic             wr_en;
    reg_idx_t         reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    // byte offset inside a register is ignored
    assign reg_idx = reg_idx_t'(paddr[4:3]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rot_row0_reg <= ROT_ROW0_RST;
            rot_row1_reg <= ROT_ROW1_RST;
            rot_row2_reg <= ROT_ROW2_RST;
            trans_reg    <= TRANS_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_ROT_ROW0: rot_row0_reg <= pwdata[REG_W-1:0];
                REG_ROT_ROW1: rot_row1_reg <= pwdata[REG_W-1:0];
                REG_ROT_ROW2: rot_row2_reg <= pwdata[REG_W-1:0];
                REG_TRANS:    trans_reg    <= pwdata[REG_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_ROT_ROW0: prdata = {{(PDATA_W-REG_W){1'b0}}, rot_row0_reg};
            REG_ROT_ROW1: prdata = {{(PDATA_W-REG_W){1'b0}}, rot_row1_reg};
            REG_ROT_ROW2: prdata = {{(PDATA_W-REG_W){1'b0}}, rot_row2_reg};
            REG_TRANS:    prdata = {{(PDATA_W-REG_W){1'b0}}, trans_reg};
            default:      prdata = '0;
        endcase
    end

    assign cfg.rot_row0 = rot_row0_reg;
    assign cfg.rot_row1 = rot_row1_reg;
    assign cfg.rot_row2 = rot_row2_reg;
    assign cfg.trans    = trans_reg;

endmodule

FILE: rtl/core/zrwp_datapath.sv
// zrwp_datapath: six-register pipeline for projection, rotation, translation,
// rounding and saturation. Depends on zrwp_pkg.
module zrwp_datapath
    import zrwp_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  cfg_t                      cfg,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [DIST_W-1:0]  in_distance,
    input  logic [IDX_W-1:0]          in_row,
    input  logic [IDX_W-1:0]          in_col,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      out_point_valid,
    output logic signed [COORD_W-1:0] out_x,
    output logic signed [COORD_W-1:0] out_y,
    output logic signed [COORD_W-1:0] out_z,
    output logic signed [DIST_W-1:0]  out_range
);

    logic [REG_W-1:0] rot [NUM_AXES];
    logic             v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic             rdy0, rdy1, rdy2, rdy3, rdy4, rdy5;

    // stage 0: input capture
    logic signed [DIST_W-1:0] d0_reg;
    logic [IDX_W-1:0]         row0_reg, col0_reg;
    logic                     pos0_reg;
    // stage 1: table lookup and first products
    logic signed [DIST_W-1:0] d1_reg;
    logic                     pos1_reg;
    logic signed [31:0]       dc1_reg, ds1_reg;
    logic signed [31:0]       a1_reg [NUM_AXES];
    logic signed [31:0]       b1_reg [NUM_AXES];
    // stage 2: full products
    logic signed [DIST_W-1:0] d2_reg;
    logic                     pos2_reg;
    logic signed [63:0]       p2_reg [NUM_AXES];
    logic signed [63:0]       q2_reg [NUM_AXES];
    logic signed [47:0]       y2_reg [NUM_AXES];
    // stage 3: partial sums
    logic signed [DIST_W-1:0] d3_reg;
    logic                     pos3_reg;
    logic signed [63:0]       s3a_reg [NUM_AXES];
    logic signed [63:0]       s3b_reg [NUM_AXES];
    // stage 4: Q42 accumulators
    logic signed [DIST_W-1:0] d4_reg;
    logic                     pos4_reg;
    logic signed [63:0]       acc4_reg [NUM_AXES];
    // stage 5: output register
    logic                     pos5_reg;
    logic signed [DIST_W-1:0] d5_reg;
    logic signed [COORD_W-1:0] w5_reg [NUM_AXES];

    logic signed [COEF_W-1:0] sin_row, cos_row, sin_col, cos_col;
    logic signed [21:0]       whole [NUM_AXES];
    logic signed [COORD_W-1:0] sat_next [NUM_AXES];

    assign rot[0] = cfg.rot_row0;
    assign rot[1] = cfg.rot_row1;
    assign rot[2] = cfg.rot_row2;

    // a stage takes new data when empty or when its successor moves
    assign rdy5     = !v5_reg || out_ready;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign rdy0     = !v0_reg || rdy1;
    assign in_ready = rdy0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (rdy0) v0_reg <= in_valid;
            if (rdy1) v1_reg <= v0_reg;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    assign sin_row = sin_q14(row0_reg);
    assign cos_row = cos_q14(row0_reg);
    assign sin_col = sin_q14(col0_reg);
    assign cos_col = cos_q14(col0_reg);

    always_comb begin
        for (int r = 0; r < NUM_AXES; r++) begin
            // acc already carries the half LSB, so the top bits are the rounded value
            whole[r] = acc4_reg[r][63:42];
            if (whole[r] > 22'(COORD_MAX)) begin
                sat_next[r] = COORD_MAX;
            end else if (whole[r] < 22'(COORD_MIN)) begin
                sat_next[r] = COORD_MIN;
            end else begin
                sat_next[r] = whole[r][COORD_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy0) begin
            d0_reg   <= in_distance;
            row0_reg <= in_row;
            col0_reg <= in_col;
            pos0_reg <= !in_distance[DIST_W-1] && (in_distance != '0);
        end
        if (rdy1) begin
            d1_reg   <= d0_reg;
            pos1_reg <= pos0_reg;
            dc1_reg  <= 32'(d0_reg) * 32'(cos_col);
            ds1_reg  <= 32'(d0_reg) * 32'(sin_col);
            // R[r][0]*sin(row) and R[r][2]*cos(row) fold the row angle in early
            for (int r = 0; r < NUM_AXES; r++) begin
                a1_reg[r] <= 32'(lane16(rot[r], 2'd0)) * 32'(sin_row);
                b1_reg[r] <= 32'(lane16(rot[r], 2'd2)) * 32'(cos_row);
            end
        end
        if (rdy2) begin
            d2_reg   <= d1_reg;
            pos2_reg <= pos1_reg;
            for (int r = 0; r < NUM_AXES; r++) begin
                p2_reg[r] <= 64'(a1_reg[r]) * 64'(dc1_reg);
                q2_reg[r] <= 64'(b1_reg[r]) * 64'(dc1_reg);
                y2_reg[r] <= 48'(lane16(rot[r], 2'd1)) * 48'(ds1_reg);
            end
        end
        if (rdy3) begin
            d3_reg   <= d2_reg;
            pos3_reg <= pos2_reg;
            for (int r = 0; r < NUM_AXES; r++) begin
                s3a_reg[r] <= p2_reg[r] + q2_reg[r];
                s3b_reg[r] <= (64'(y2_reg[r]) <<< 14)
                            + (64'(lane16(cfg.trans, 2'(r))) <<< 42) + ROUND_HALF;
            end
        end
        if (rdy4) begin
            d4_reg   <= d3_reg;
            pos4_reg <= pos3_reg;
            for (int r = 0; r < NUM_AXES; r++) begin
                acc4_reg[r] <= s3a_reg[r] + s3b_reg[r];
            end
        end
        if (rdy5) begin
            pos5_reg <= pos4_reg;
            d5_reg   <= pos4_reg ? d4_reg : '0;
            for (int r = 0; r < NUM_AXES; r++) begin
                w5_reg[r] <= pos4_reg ? sat_next[r] : '0;
            end
        end
    end

    assign out_valid       = v5_reg;
    assign out_point_valid = pos5_reg;
    assign out_x           = w5_reg[0];
    assign out_y           = w5_reg[1];
    assign out_z           = w5_reg[2];
    assign out_range       = d5_reg;

endmodule

FILE: rtl/core/zone_range_to_world_point_top.sv
// Zone range to world point: one request in, one point out, in order.
// An accepted request passes stage registers 0 to 5; the last drives m_tvalid.
// Throughput: 1 request per cycle while m_tready is high, set by the six-register
// multiply/add pipeline. Stages without data accept even while the output is stalled.
// Reset (aresetn low, synchronous) empties the pipeline and loads the identity
// matrix and zero translation.
module zone_range_to_world_point_top
    import zrwp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [23:0]        s_tdata,  // zone_range[15:0], zone_row[18:16], zone_col[21:19]
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [71:0]        m_tdata,  // point_x[17:0], point_y[35:18], point_z[53:36],
                                         // range_out[69:54]
    output logic               m_tuser,  // point_valid
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    cfg_t                      cfg;
    logic signed [COORD_W-1:0] point_x, point_y, point_z;
    logic signed [DIST_W-1:0]  range_out;

    zrwp_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    zrwp_datapath u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .in_distance     ($signed(s_tdata[15:0])),
        .in_row          (s_tdata[18:16]),
        .in_col          (s_tdata[21:19]),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_point_valid (m_tuser),
        .out_x           (point_x),
        .out_y           (point_y),
        .out_z           (point_z),
        .out_range       (range_out)
    );

    assign m_tdata = {2'b00, range_out, point_z, point_y, point_x};

endmodule

FILE: rtl/core/zrwp_checker.sv
// zrwp_checker: port-level assertions for zone_range_to_world_point_top, with its bind.
// Depends on nothing but the top level's port names.
module zrwp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata,
    input logic        m_tuser
);

    // stalled result stays up
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // invalid distance gives an all-zero payload
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == 72'd0)
        else $error("invalid point with nonzero payload");

    // a valid point always carries a positive range
    a_valid_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> !m_tdata[69] && (m_tdata[69:54] != 16'd0))
        else $error("valid point with nonpositive range");

    // a draining output never blocks the input side
    a_no_block: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input blocked while output is ready");

endmodule

bind zone_range_to_world_point_top zrwp_checker u_zrwp_checker (.*);

FILE: test/zone_range_to_world_point_top_tb.sv
// Self-checking bench for zone_range_to_world_point_top: streams zones, programs the
// matrix and translation over APB and compares every point against a local projection.
// Depends on zrwp_pkg and the RTL only.
import zrwp_pkg::*;

typedef struct {
    logic                      valid;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic signed [DIST_W-1:0]  range_mm;
} world_point_t;

// Holds the register copy, the angle tables and the points still owed by the block
class zone_point_board;
    localparam longint unsigned PI_Q30 = 64'd3373259426;
    localparam int GRID = 8;
    localparam int FOV_DEG = 45;
    localparam int SHOW_LIMIT = 10;

    longint           sin_lut[GRID];
    longint           cos_lut[GRID];
    logic [REG_W-1:0] cfg_regs[4];
    world_point_t     pending_points[$];
    int               mismatches;

    function new();
        cfg_regs[REG_ROT_ROW0] = ROT_ROW0_RST;
        cfg_regs[REG_ROT_ROW1] = ROT_ROW1_RST;
        cfg_regs[REG_ROT_ROW2] = ROT_ROW2_RST;
        cfg_regs[REG_TRANS]    = TRANS_RST;
        mismatches = 0;
        build_angle_tables();
    endfunction

    // Taylor series in Q30, nine terms, then rounded to nearest Q2.14
    function void build_angle_tables();
        longint unsigned den, mag, t, st, ct, s, c;
        longint num, ss, cs;
        den = 360 * (GRID - 1);
        for (int i = 0; i < GRID; i++) begin
            num = FOV_DEG * (2 * i - (GRID - 1));
            mag = (num < 0) ? -num : num;
            t = (mag * PI_Q30 + den / 2) / den;
            st = t;
            ct = 64'd1 << 30;
            ss = t;
            cs = 64'sd1 <<< 30;
            for (int k = 1; k <= 8; k++) begin
                st = ((((st * t) >> 30) * t) >> 30) / (2 * k * (2 * k + 1));
                ct = ((((ct * t) >> 30) * t) >> 30) / ((2 * k - 1) * (2 * k));
                if (k % 2 == 1) begin
                    ss -= st;
                    cs -= ct;
                end else begin
                    ss += st;
                    cs += ct;
                end
            end
            s = (ss < 0) ? 0 : ss;
            c = (cs < 0) ? 0 : cs;
            sin_lut[i] = (s + 32768) >> 16;
            if (num < 0)
                sin_lut[i] = -sin_lut[i];
            cos_lut[i] = (c + 32768) >> 16;
        end
    endfunction

    function longint coef_at(logic [REG_W-1:0] w, int lane);
        logic signed [COEF_W-1:0] c16;
        c16 = w[COEF_W*lane +: COEF_W];
        return c16;
    endfunction

    // Q42 sum, round half up, clamp to 18 bits
    function logic signed [COORD_W-1:0] axis_mm(reg_idx_t r, int axis,
                                                  longint xs, longint ys, longint zs);
        longint          acc, v;
        longint unsigned u;
        acc = coef_at(cfg_regs[r], 0) * xs + coef_at(cfg_regs[r], 1) * ys +
              coef_at(cfg_regs[r], 2) * zs +
              coef_at(cfg_regs[REG_TRANS], axis) * (64'sd1 <<< 42);
        u = acc + (64'sd1 <<< 62) + (64'sd1 <<< 41);
        u = u >> 42;
        v = longint'(u) - (64'sd1 <<< 20);
        if (v > COORD_MAX)
            v = COORD_MAX;
        if (v < COORD_MIN)
            v = COORD_MIN;
        return v[COORD_W-1:0];
    endfunction

    function world_point_t project_zone(logic signed [DIST_W-1:0] range_in,
                                        logic [IDX_W-1:0] row, logic [IDX_W-1:0] col);
        world_point_t p;
        longint       d, xs, ys, zs;
        p = '{default: '0};
        if (range_in > 0) begin
            d = range_in;
            xs = d * sin_lut[row] * cos_lut[col];
            ys = d * sin_lut[col] * 16384;
            zs = d * cos_lut[row] * cos_lut[col];
            p.valid = 1'b1;
            p.x = axis_mm(REG_ROT_ROW0, 0, xs, ys, zs);
            p.y = axis_mm(REG_ROT_ROW1, 1, xs, ys, zs);
            p.z = axis_mm(REG_ROT_ROW2, 2, xs, ys, zs);
            p.range_mm = range_in;
        end
        return p;
    endfunction

    function void note_request(logic [DIST_W-1:0] range_in, logic [IDX_W-1:0] row,
                               logic [IDX_W-1:0] col);
        pending_points.push_back(project_zone(range_in, row, col));
    endfunction

    function void flag(string what, longint want, longint got);
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
            $display("mismatch %s: expected %0d, got %0d", what, want, got);
    endfunction

    function void check_point(logic [71:0] data, logic user);
        world_point_t              want;
        logic signed [COORD_W-1:0] gx, gy, gz;
        logic signed [DIST_W-1:0]  gr;
        gx = data[17:0];
        gy = data[35:18];
        gz = data[53:36];
        gr = data[69:54];
        if (pending_points.size() == 0) begin
            flag("point with no request pending, x", 0, gx);
            return;
        end
        want = pending_points.pop_front();
        if (user !== want.valid)
            flag("point_valid", want.valid, user);
        if (gx !== want.x)
            flag("point_x", want.x, gx);
        if (gy !== want.y)
            flag("point_y", want.y, gy);
        if (gz !== want.z)
            flag("point_z", want.z, gz);
        if (gr !== want.range_mm)
            flag("range_out", want.range_mm, gr);
    endfunction
endclass

module zone_range_to_world_point_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import zrwp_pkg::*;

    localparam int RESET_CYCLES    = 12;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int SETTLE_CYCLES   = 12;
    localparam int LONG_HOLD       = 150;
    localparam int CYCLE_LIMIT     = 300000;

    typedef enum int {
        SET_IDENTITY, SET_ONES, SET_ZEROS, SET_MAX, SET_MIN, SET_RANDOM
    } setting_t;
    typedef enum int {RX_ALWAYS, RX_COIN, RX_PATTERN} rx_mode_t;

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic [23:0]        s_tdata  = '0;
    logic               m_tready = 1'b0;
    logic               psel     = 1'b0;
    logic               penable  = 1'b0;
    logic               pwrite   = 1'b0;
    logic [PADDR_W-1:0] paddr    = '0;
    logic [PDATA_W-1:0] pwdata   = '0;
    logic               s_tready;
    logic               m_tvalid;
    logic [71:0]        m_tdata;
    logic               m_tuser;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    zone_point_board board;

    rx_mode_t    rx_mode     = RX_ALWAYS;
    logic [15:0] rx_pattern  = 16'hF0CA;
    bit          hold_req    = 1'b0;
    int          hold_left   = 0;
    bit          tx_bursty   = 1'b0;
    int          burst_left  = 0;
    int unsigned cycle_count = 0;

    zone_range_to_world_point_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("zone_range_to_world_point_top_tb: FAIL");
            $finish;
        end
    end

    // Result side backpressure; a long hold overrides the current pattern
    always @(posedge aclk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS: m_tready <= 1'b1;
                RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
                default: begin
                    m_tready   <= rx_pattern[0];
                    rx_pattern <= {rx_pattern[0], rx_pattern[15:1]};
                end
            endcase
        end
    end

    always @(posedge aclk)
        if (aresetn && m_tvalid && m_tready)
            board.check_point(m_tdata, m_tuser);

    // Entered and left on a rising edge; valid stays up across back-to-back requests
    task automatic send_zone(input logic [DIST_W-1:0] range_in, input logic [IDX_W-1:0] row,
                             input logic [IDX_W-1:0] col);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, col, row, range_in};
        do @(posedge aclk); while (!s_tready);
        board.note_request(range_in, row, col);
        if (tx_bursty) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap = $urandom_range(1, 12);
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (board.pending_points.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Each transfer ends with psel and penable dropped, the bus idle before the task returns
    task automatic apb_write(input reg_idx_t idx, input logic [PDATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        board.cfg_regs[idx] = val[REG_W-1:0];
        @(posedge aclk);
    endtask

    task automatic apb_read(input reg_idx_t idx);
        logic [PDATA_W-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 3'b000};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== {{(PDATA_W-REG_W){1'b0}}, board.cfg_regs[idx]})
            board.flag("register readback", board.cfg_regs[idx], got);
        @(posedge aclk);
    endtask

    task automatic check_regs();
        apb_read(REG_ROT_ROW0);
        apb_read(REG_ROT_ROW1);
        apb_read(REG_ROT_ROW2);
        apb_read(REG_TRANS);
    endtask

    task automatic load_setting(input setting_t kind);
        logic [PDATA_W-1:0] row0, row1, row2, trans;
        case (kind)
            SET_IDENTITY: begin
                row0  = ROT_ROW0_RST;
                row1  = ROT_ROW1_RST;
                row2  = ROT_ROW2_RST;
                trans = TRANS_RST;
            end
            SET_ONES: begin
                row0  = '1;
                row1  = '1;
                row2  = '1;
                trans = '1;
            end
            SET_ZEROS: begin
                row0  = '0;
                row1  = '0;
                row2  = '0;
                trans = '0;
            end
            SET_MAX: begin
                row0  = 64'h0000_7FFF_7FFF_7FFF;
                row1  = 64'h0000_7FFF_7FFF_7FFF;
                row2  = 64'h0000_7FFF_7FFF_7FFF;
                trans = 64'h0000_7FFF_7FFF_7FFF;
            end
            SET_MIN: begin
                // upper bits are junk and must be dropped
                row0  = 64'hA5A5_8000_8000_8000;
                row1  = 64'h5A5A_8000_8000_8000;
                row2  = 64'hFFFF_8000_8000_8000;
                trans = 64'h0F0F_8000_8000_8000;
            end
            default: begin
                row0  = {$urandom, $urandom};
                row1  = {$urandom, $urandom};
                row2  = {$urandom, $urandom};
                trans = {$urandom, $urandom};
            end
        endcase
        apb_write(REG_ROT_ROW0, row0);
        apb_write(REG_ROT_ROW1, row1);
        apb_write(REG_ROT_ROW2, row2);
        apb_write(REG_TRANS, trans);
        check_regs();
    endtask

    function automatic logic [DIST_W-1:0] pick_distance();
        logic [DIST_W-1:0] corners[5];
        corners = '{16'h7FFF, 16'h0001, 16'h0000, 16'h8000, 16'hFFFF};
        case ($urandom_range(0, 9))
            0:       return {1'b1, 15'($urandom)};
            1:       return corners[$urandom_range(0, 4)];
            2:       return 16'($urandom);
            default: return 16'($urandom_range(1, 32767));
        endcase
    endfunction

    // Full range from one octant to the opposite, both saturation directions
    task automatic send_corner_zones();
        send_zone(16'h7FFF, 3'd7, 3'd7);
        send_zone(16'h7FFF, 3'd0, 3'd0);
        send_zone(16'h7FFF, 3'd7, 3'd0);
    endtask

    initial begin
        setting_t plan[7];
        plan = '{SET_IDENTITY, SET_ONES, SET_MAX, SET_MIN, SET_ZEROS, SET_RANDOM,
                 SET_RANDOM};
        board = new();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        check_regs();

        // invalid distances, extremes and every row/column at reset config
        send_zone(16'h0001, 3'd0, 3'd0);
        send_zone(16'h7FFF, 3'd7, 3'd7);
        send_zone(16'h7FFF, 3'd0, 3'd7);
        send_zone(16'h7FFF, 3'd7, 3'd0);
        send_zone(16'h0000, 3'd3, 3'd4);
        send_zone(16'hFFFF, 3'd2, 3'd5);
        send_zone(16'h8000, 3'd7, 3'd7);
        for (int r = 0; r < 8; r++)
            send_zone(16'(1000 + 37 * r), 3'(r), 3'(7 - r));

        for (int p = 0; p < 7; p++) begin
            wait_drain();
            load_setting(plan[p]);
            if (plan[p] == SET_MAX || plan[p] == SET_MIN)
                send_corner_zones();
            rx_mode   = rx_mode_t'(p % 3);
            tx_bursty = (p % 2 == 1);
            burst_left = 0;
            // stall the output long enough for the pipeline to back up
            if (p == 2)
                hold_req = 1'b1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_zone(pick_distance(), 3'($urandom), 3'($urandom));
        end
        wait_drain();

        if (board.mismatches == 0 && board.pending_points.size() == 0)
            $display("zone_range_to_world_point_top_tb: PASS");
        else
            $display("zone_range_to_world_point_top_tb: FAIL");
        $finish;
    end

endmodule

FILE: zone_range_to_world_point_top.f
rtl/core/zrwp_pkg.sv
rtl/core/zrwp_cfg_regs.sv
rtl/core/zrwp_datapath.sv
rtl/core/zone_range_to_world_point_top.sv
rtl/core/zrwp_checker.sv
test/zone_range_to_world_point_top_tb.sv
